// ----- rtl/lesf_pkg.sv -----
// shared constants and types for the largest empty square finder
package lesf_pkg;

    // default sizes of the map
    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 65536;

    // widths of the configuration registers and the input character
    localparam int CFG_ROWS_W = 17;
    localparam int CFG_COLS_W = 11;
    localparam int CHAR_W     = 8;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;

    // register reset values
    localparam logic [CFG_ROWS_W-1:0] NUM_ROWS_RST   = CFG_ROWS_W'(1);
    localparam logic [CFG_COLS_W-1:0] NUM_COLS_RST   = CFG_COLS_W'(1);
    localparam logic [CHAR_W-1:0]     EMPTY_CHAR_RST = CHAR_W'(46);

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_NUM_ROWS   = 2'd0;
    localparam t_cfg_idx CFG_NUM_COLS   = 2'd1;
    localparam t_cfg_idx CFG_EMPTY_CHAR = 2'd2;

    // result queue depth
    localparam int OUTQ_DEPTH = 2;

endpackage

// ----- rtl/lesf_ram.sv -----
// generic simple dual-port ram with registered read
module lesf_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/lesf_outq.sv -----
// two-entry result queue in front of the output channel
module lesf_outq #(
    parameter int WIDTH = 37
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_stall,
    output logic [1:0]       o_count
);

    logic [WIDTH-1:0] r_slot [lesf_pkg::OUTQ_DEPTH];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic             pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rd_ptr];
    assign o_count = r_cnt;
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // the producer reserves a slot before it sends a request that ends a map
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < 2'd2))
        else $error("result queue overflow");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result queue count out of range");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_rd_ptr != $past(r_rd_ptr)))
        else $error("read pointer did not advance on pop");

endmodule

// ----- rtl/largest_empty_square_finder.sv -----
// top level of the largest empty square finder: line buffer scoring and result tracking
//
// Map cells arrive one per request in raster order, one character each. The block
// takes one cell every clock cycle at full rate: a cell is accepted, the score of the
// cell above it is read from the line buffer ram (one read port, registered read),
// and in the following cycle the cell's score is formed from that value, the score to
// the left and the diagonal score, written back into the line buffer and compared
// with the best so far. When the cell read and the cell written in the same cycle are
// the same column (a one-column map), the score being written is forwarded. An empty
// cell (equal to the empty_char register) scores 1 in the first row or column and
// otherwise one plus the minimum of its three neighbors; any other character scores
// 0. Only a strictly larger score replaces the best, so the first such square in
// raster order wins. The cell that completes the map yields one result (size and
// top-left corner, all zero if no cell is empty) once it has been scored, and the
// block then starts the next map from clean state. Results wait in a
// two-entry queue; a cell that ends a map is stalled only while two results are
// already pending, other cells are never stalled. Size register values of 0 act as 1 and
// values beyond the maximum saturate; the registers may be rewritten between cells.
// The line buffer needs no clearing pass after reset: columns are first written in
// increasing order, so a fill mark tells which entries hold data, and an entry
// beyond it reads as zero.
module largest_empty_square_finder #(
    parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // configuration write channel
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  lesf_pkg::t_cfg_idx                          i_cfg_index,
    input  logic [lesf_pkg::CFG_DATA_W-1:0]             i_cfg_data,
    // cell input channel
    input  logic                                        i_in_valid,
    output logic                                        o_in_stall,
    input  logic [lesf_pkg::CHAR_W-1:0]                 i_cell_char,
    // result output channel
    output logic                                        o_out_valid,
    input  logic                                        i_out_stall,
    output logic [$clog2(MAX_COLS+1)-1:0]               o_square_size,
    output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] o_top_row,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] o_left_col
);

    // widths derived from the map limits
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SC_W   = $clog2(MAX_COLS + 1);
    localparam int RCMP_W = (ROW_W + 1 > lesf_pkg::CFG_ROWS_W) ?
                            ROW_W + 1 : lesf_pkg::CFG_ROWS_W;
    localparam int CCMP_W = (COL_W + 1 > lesf_pkg::CFG_COLS_W) ?
                            COL_W + 1 : lesf_pkg::CFG_COLS_W;
    localparam int TR_W   = (ROW_W > SC_W) ? ROW_W : SC_W;
    localparam int LC_W   = (COL_W > SC_W) ? COL_W : SC_W;
    localparam int RES_W  = SC_W + ROW_W + COL_W;

    // configuration registers
    logic [lesf_pkg::CFG_ROWS_W-1:0] r_num_rows;
    logic [lesf_pkg::CFG_COLS_W-1:0] r_num_cols;
    logic [lesf_pkg::CHAR_W-1:0]     r_empty_char;

    // accept side: position of the next cell
    logic [COL_W-1:0] r_col_cnt;
    logic [ROW_W-1:0] r_row_cnt;

    // scoring stage: one cell whose line buffer read is in flight
    logic                      r_s_valid;
    logic [lesf_pkg::CHAR_W-1:0] r_s_char;
    logic [COL_W-1:0]          r_s_col;
    logic [ROW_W-1:0]          r_s_row;
    logic                      r_s_first;
    logic                      r_s_row_end;
    logic                      r_s_map_end;
    logic                      r_up_ok;
    logic                      r_fwd;
    logic [SC_W-1:0]           r_fwd_score;

    // running state of the current map
    logic [SC_W-1:0]  r_left;
    logic [SC_W-1:0]  r_diag;
    logic [SC_W-1:0]  r_best_size;
    logic [ROW_W-1:0] r_best_row;
    logic [COL_W-1:0] r_best_col;
    logic [SC_W-1:0]  r_fill;

    // effective map size
    logic [RCMP_W-1:0] rows_ext;
    logic [RCMP_W-1:0] rows_eff;
    logic [RCMP_W-1:0] rows_m1;
    logic [CCMP_W-1:0] cols_ext;
    logic [CCMP_W-1:0] cols_eff;
    logic [CCMP_W-1:0] cols_m1;
    logic [ROW_W-1:0]  row_last;
    logic [COL_W-1:0]  col_last;

    logic             in_acc;
    logic             row_end_nx;
    logic             map_end_nx;
    logic [1:0]       q_count;
    logic [1:0]       pending;

    logic [SC_W-1:0]  ram_q;
    logic [SC_W-1:0]  up;
    logic [SC_W-1:0]  min_ul;
    logic [SC_W-1:0]  min_all;
    logic [SC_W-1:0]  score;
    logic             better;
    logic [SC_W-1:0]  b_size;
    logic [ROW_W-1:0] b_row;
    logic [COL_W-1:0] b_col;
    logic [TR_W-1:0]  tr_wide;
    logic [LC_W-1:0]  lc_wide;
    logic [ROW_W-1:0] res_row;
    logic [COL_W-1:0] res_col;
    logic             push;
    logic [RES_W-1:0] push_data;
    logic [RES_W-1:0] head_data;

    // ---------------------------------------------------------------
    // configuration port, always ready
    // ---------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows   <= lesf_pkg::NUM_ROWS_RST;
            r_num_cols   <= lesf_pkg::NUM_COLS_RST;
            r_empty_char <= lesf_pkg::EMPTY_CHAR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lesf_pkg::CFG_NUM_ROWS: begin
                    r_num_rows <= i_cfg_data[lesf_pkg::CFG_ROWS_W-1:0];
                end
                lesf_pkg::CFG_NUM_COLS: begin
                    r_num_cols <= i_cfg_data[lesf_pkg::CFG_COLS_W-1:0];
                end
                lesf_pkg::CFG_EMPTY_CHAR: begin
                    r_empty_char <= i_cfg_data[lesf_pkg::CHAR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, oversize saturates
    always_comb begin
        rows_ext = RCMP_W'(r_num_rows);
        if (rows_ext == '0) begin
            rows_eff = RCMP_W'(1);
        end else if (rows_ext > RCMP_W'(MAX_ROWS)) begin
            rows_eff = RCMP_W'(MAX_ROWS);
        end else begin
            rows_eff = rows_ext;
        end
        cols_ext = CCMP_W'(r_num_cols);
        if (cols_ext == '0) begin
            cols_eff = CCMP_W'(1);
        end else if (cols_ext > CCMP_W'(MAX_COLS)) begin
            cols_eff = CCMP_W'(MAX_COLS);
        end else begin
            cols_eff = cols_ext;
        end
    end

    assign rows_m1  = rows_eff - RCMP_W'(1);
    assign cols_m1  = cols_eff - CCMP_W'(1);
    assign row_last = rows_m1[ROW_W-1:0];
    assign col_last = cols_m1[COL_W-1:0];

    // ---------------------------------------------------------------
    // accept side: position tracking and flow control
    // ---------------------------------------------------------------
    assign row_end_nx = (r_col_cnt >= col_last);
    assign map_end_nx = row_end_nx && (r_row_cnt >= row_last);

    // results queued plus one still being scored
    assign pending    = q_count + {1'b0, r_s_valid && r_s_map_end};
    // only a map-ending cell needs a free result slot
    assign o_in_stall = map_end_nx && (pending >= 2'd2);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_s_valid <= 1'b0;
        end else begin
            r_s_valid <= in_acc;
            if (in_acc) begin
                if (map_end_nx) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= '0;
                end else if (row_end_nx) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= r_row_cnt + ROW_W'(1);
                end else begin
                    r_col_cnt <= r_col_cnt + COL_W'(1);
                end
            end
        end
    end

    // cell payload into the scoring stage, plus forwarding of a same-column write
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s_char    <= i_cell_char;
            r_s_col     <= r_col_cnt;
            r_s_row     <= r_row_cnt;
            r_s_first   <= (r_row_cnt == '0) || (r_col_cnt == '0);
            r_s_row_end <= row_end_nx;
            r_s_map_end <= map_end_nx;
            r_up_ok     <= (SC_W'(r_col_cnt) < r_fill);
            r_fwd       <= r_s_valid && (r_s_col == r_col_cnt);
            r_fwd_score <= score;
        end
    end

    // ---------------------------------------------------------------
    // line buffer of the previous row's scores
    // ---------------------------------------------------------------
    lesf_ram #(
        .WIDTH (SC_W),
        .DEPTH (MAX_COLS)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (r_s_valid),
        .i_wr_addr (r_s_col),
        .i_wr_data (score),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col_cnt),
        .o_rd_data (ram_q)
    );

    // ---------------------------------------------------------------
    // scoring stage
    // ---------------------------------------------------------------
    // columns past the fill mark have never been written since reset
    assign up      = r_fwd ? r_fwd_score : (r_up_ok ? ram_q : '0);
    assign min_ul  = (up < r_left) ? up : r_left;
    assign min_all = (r_diag < min_ul) ? r_diag : min_ul;

    always_comb begin
        if (r_s_char != r_empty_char) begin
            score = '0;
        end else if (r_s_first) begin
            score = SC_W'(1);
        end else begin
            score = min_all + SC_W'(1);
        end
    end

    // strictly larger only, first square in raster order wins
    assign better = (score > r_best_size);
    assign b_size = better ? score   : r_best_size;
    assign b_row  = better ? r_s_row : r_best_row;
    assign b_col  = better ? r_s_col : r_best_col;

    // best position is the bottom-right cell, turn it into the top-left corner
    assign tr_wide = TR_W'(b_row) + TR_W'(1) - TR_W'(b_size);
    assign lc_wide = LC_W'(b_col) + LC_W'(1) - LC_W'(b_size);
    assign res_row = (b_size == '0) ? '0 : tr_wide[ROW_W-1:0];
    assign res_col = (b_size == '0) ? '0 : lc_wide[COL_W-1:0];

    assign push      = r_s_valid && r_s_map_end;
    assign push_data = {b_size, res_row, res_col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_diag      <= '0;
            r_best_size <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
            r_fill      <= '0;
        end else if (r_s_valid) begin
            if (SC_W'(r_s_col) >= r_fill) begin
                r_fill <= SC_W'(r_s_col) + SC_W'(1);
            end
            if (r_s_map_end) begin
                // clean state for the next map
                r_left      <= '0;
                r_diag      <= '0;
                r_best_size <= '0;
                r_best_row  <= '0;
                r_best_col  <= '0;
            end else begin
                r_best_size <= b_size;
                r_best_row  <= b_row;
                r_best_col  <= b_col;
                if (r_s_row_end) begin
                    r_left <= '0;
                    r_diag <= '0;
                end else begin
                    r_left <= score;
                    r_diag <= up;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result queue
    // ---------------------------------------------------------------
    lesf_outq #(
        .WIDTH (RES_W)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_valid (o_out_valid),
        .o_data  (head_data),
        .i_stall (i_out_stall),
        .o_count (q_count)
    );

    assign o_square_size = head_data[RES_W-1 -: SC_W];
    assign o_top_row     = head_data[COL_W +: ROW_W];
    assign o_left_col    = head_data[COL_W-1:0];

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // the fill mark only grows
    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fill >= $past(r_fill)))
        else $error("line buffer fill mark decreased");

    // a write never skips past the fill mark
    a_write_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid |-> (SC_W'(r_s_col) <= r_fill))
        else $error("line buffer written beyond fill mark");

    // pending results never exceed the queue
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pending <= 2'd2)
        else $error("more results pending than queue slots");

    // a forwarded score belongs to a cell committed in the previous cycle
    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_s_valid && (r_s_col == r_col_cnt)) |=> (r_fwd && r_s_valid))
        else $error("same-column write not forwarded");

endmodule

// ----- tb/tb_largest_empty_square_finder.sv -----
// self-checking testbench for the largest empty square finder against a score predictor
`timescale 1ns / 100ps

module tb_largest_empty_square_finder;
    import lesf_pkg::*;

    // index past the last register, writes to it must change nothing
    localparam t_cfg_idx CFG_SPARE = 2'd3;

    localparam int SIZE_W        = $clog2(MAX_COLS_DEF + 1);
    localparam int ROW_W         = $clog2(MAX_ROWS_DEF);
    localparam int COL_W         = $clog2(MAX_COLS_DEF);
    localparam int QUIET_LIMIT   = 4000;   // cycles with no request moving on any channel
    localparam int SETTLE_CYCLES = 8;      // pipeline drain before a register write
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int MAX_REPORTS   = 10;
    localparam int TALL_CELLS    = 200;    // rows pushed into the saturated-height map
    localparam int RANDOM_CELLS  = 750;
    localparam int CALM_CELLS    = 550;    // no idling after this many random cells

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_square;

    // dut inputs, all known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index = CFG_NUM_ROWS;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [CHAR_W-1:0]     i_cell_char = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [SIZE_W-1:0]     o_square_size;
    logic [ROW_W-1:0]      o_top_row;
    logic [COL_W-1:0]      o_left_col;

    largest_empty_square_finder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cell_char   (i_cell_char),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_square_size (o_square_size),
        .o_top_row     (o_top_row),
        .o_left_col    (o_left_col)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor: register copies and scoring state, all at reset values
    // ------------------------------------------------------------------
    logic [CFG_ROWS_W-1:0] map_rows  = NUM_ROWS_RST;
    logic [CFG_COLS_W-1:0] map_cols  = NUM_COLS_RST;
    logic [CHAR_W-1:0]     map_empty = EMPTY_CHAR_RST;

    logic [SIZE_W-1:0] line_buf [MAX_COLS_DEF];
    logic [SIZE_W-1:0] left_sc  = '0;
    logic [SIZE_W-1:0] diag_sc  = '0;
    logic [ROW_W-1:0]  row_cnt  = '0;
    logic [COL_W-1:0]  col_cnt  = '0;
    logic [SIZE_W-1:0] best_size = '0;
    logic [ROW_W-1:0]  best_row  = '0;   // bottom-right cell of the best square
    logic [COL_W-1:0]  best_col  = '0;

    // scores one cell; returns 1 when it closes the map, with the square in sq
    function automatic bit score_cell(input logic [CHAR_W-1:0] ch, output t_square sq);
        int unsigned rows;
        int unsigned cols;
        int unsigned up;
        int unsigned score;
        bit          row_end;
        bit          map_end;
        // zero acts as one, oversize values saturate
        rows = (map_rows == 0) ? 1 : (map_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : map_rows;
        cols = (map_cols == 0) ? 1 : (map_cols > MAX_COLS_DEF) ? MAX_COLS_DEF : map_cols;
        up   = line_buf[col_cnt];
        if (ch != map_empty) begin
            score = 0;
        end else if (row_cnt == 0 || col_cnt == 0) begin
            score = 1;
        end else begin
            score = (up < left_sc) ? up : left_sc;
            if (diag_sc < score) score = diag_sc;
            score = score + 1;
        end
        // strictly larger only, so the first square in raster order stays
        if (score > best_size) begin
            best_size = SIZE_W'(score);
            best_row  = row_cnt;
            best_col  = col_cnt;
        end
        line_buf[col_cnt] = SIZE_W'(score);
        diag_sc = SIZE_W'(up);
        left_sc = SIZE_W'(score);
        // counters are checked against the live registers, sizes may change mid-map
        row_end = col_cnt >= cols - 1;
        map_end = row_end && row_cnt >= rows - 1;
        sq = '0;
        if (map_end) begin
            if (best_size != 0) begin
                sq.size = best_size;
                sq.row  = ROW_W'(int'(best_row) + 1 - int'(best_size));
                sq.col  = COL_W'(int'(best_col) + 1 - int'(best_size));
            end
            left_sc   = '0;
            diag_sc   = '0;
            row_cnt   = '0;
            col_cnt   = '0;
            best_size = '0;
            best_row  = '0;
            best_col  = '0;
            return 1'b1;
        end
        if (row_end) begin
            col_cnt = '0;
            row_cnt = row_cnt + 1'b1;
            left_sc = '0;
            diag_sc = '0;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // shared bookkeeping
    // ------------------------------------------------------------------
    logic [CHAR_W-1:0] cell_q[$];            // cells waiting for the driver
    t_square           expected_squares[$];  // squares predicted, not yet seen
    int unsigned       cells_queued = 0;     // written by the stimulus only
    int unsigned       cells_taken  = 0;     // written by the driver only
    int unsigned       mismatches   = 0;
    bit                idle_on      = 1'b0;  // random gaps and stalls allowed
    int unsigned       hold_reqs    = 0;     // bumped to ask for a long hold-off

    // ------------------------------------------------------------------
    // cell driver: one request per accepted cell, random gaps between
    // ------------------------------------------------------------------
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin
        logic              nxt_valid;
        logic [CHAR_W-1:0] nxt_char;
        t_square           sq;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            nxt_valid = i_in_valid;
            nxt_char  = i_cell_char;
            if (i_in_valid && !o_in_stall) begin
                // predict at the moment the cell is taken
                if (score_cell(i_cell_char, sq)) expected_squares.push_back(sq);
                cells_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cell_q.size() > 0) begin
                    if (idle_on && $urandom_range(0, 4) == 0) begin
                        // this cycle is idle too, ahead of the random gap
                        gap_left = $urandom_range(0, 10);
                    end else begin
                        nxt_valid = 1'b1;
                        nxt_char  = cell_q.pop_front();
                    end
                end
            end
            // one assignment per step, a held request is never dropped and raised
            i_in_valid  <= nxt_valid;
            i_cell_char <= nxt_char;
        end
    end

    // ------------------------------------------------------------------
    // result receiver: random stall bursts plus an on-demand long hold
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    int unsigned hold_seen  = 0;

    always @(posedge i_clk) begin
        logic nxt_stall;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_stall = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                nxt_stall = 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 10);
                nxt_stall  = 1'b1;
            end else begin
                nxt_stall = 1'b0;
            end
            i_out_stall <= nxt_stall;
        end
    end

    // ------------------------------------------------------------------
    // result checker, field by field against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_square want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_squares.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected square: size %0d row %0d col %0d",
                             o_square_size, o_top_row, o_left_col);
            end else begin
                want = expected_squares.pop_front();
                if (o_square_size !== want.size || o_top_row !== want.row ||
                    o_left_col !== want.col) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("square mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.size, want.row, want.col,
                                 o_square_size, o_top_row, o_left_col);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run when no request moves for too long
    // ------------------------------------------------------------------
    int unsigned quiet = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0) ||
            (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1) || !i_rst_n) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
                $display("tb_largest_empty_square_finder: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // one register write; leaves valid high, the caller drops it after the batch
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_NUM_ROWS:   map_rows  = val[CFG_ROWS_W-1:0];
            CFG_NUM_COLS:   map_cols  = val[CFG_COLS_W-1:0];
            CFG_EMPTY_CHAR: map_empty = val[CHAR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int unsigned rows, input int unsigned cols,
                             input int unsigned empty);
        write_reg(CFG_NUM_ROWS, CFG_DATA_W'(rows));
        write_reg(CFG_NUM_COLS, CFG_DATA_W'(cols));
        write_reg(CFG_EMPTY_CHAR, CFG_DATA_W'(empty));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until every cell is taken and every square seen, then let the pipe empty
    task automatic settle();
        do @(posedge i_clk);
        while (cells_taken != cells_queued || expected_squares.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_cell(input logic [CHAR_W-1:0] ch);
        cell_q.push_back(ch);
        cells_queued++;
    endtask

    // n cells, pct percent of them empty, the rest any character
    task automatic push_cells(input int unsigned n, input int unsigned pct);
        repeat (n) begin
            if ($urandom_range(0, 99) < pct) push_cell(map_empty);
            else push_cell(CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int unsigned rcells;
        int unsigned rows;
        int unsigned cols;
        int unsigned area;
        int unsigned target;
        int unsigned phase;
        logic [CHAR_W-1:0] ch;

        foreach (line_buf[i]) line_buf[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config is a 1x1 map with '.' as empty
        idle_on = 1'b1;
        push_cell(8'd46);
        push_cell(8'd111);
        push_cell(8'd0);
        push_cell(8'd255);
        settle();

        // zero sizes act as one; spare index must not disturb anything
        write_reg(CFG_SPARE, '1);
        configure(0, 0, 0);
        push_cell(8'd0);
        push_cell(8'd46);
        settle();

        // fully empty 3x3 with the top character as empty
        configure(3, 3, 255);
        repeat (9) push_cell(8'd255);
        settle();

        // 2x3 with a blocked corner, square sits off the origin
        configure(2, 3, 46);
        push_cell(8'd111);
        repeat (5) push_cell(8'd46);
        settle();

        // map shrunk mid-way: the next cell finds itself at the new row end
        configure(3, 4, 46);
        repeat (5) push_cell(8'd46);
        settle();
        configure(2, 2, 46);
        push_cell(8'd46);
        settle();

        // tall map, rows saturate, one column, first empty row further down;
        // the map must stay open, then a shrink to one row closes it
        idle_on = 1'b0;
        configure(17'h1FFFF, 1, 120);
        target = $urandom_range(20, TALL_CELLS - 1);
        for (int unsigned r = 0; r < TALL_CELLS; r++) begin
            ch = CHAR_W'($urandom_range(0, 255));
            if (ch == map_empty) ch = ch ^ 8'h01;
            if (r == target || (r > target && $urandom_range(0, 7) == 0)) ch = map_empty;
            push_cell(ch);
        end
        settle();
        configure(1, 1, 120);
        push_cell(8'd120);
        settle();

        // widest row: width saturates at the maximum
        idle_on = 1'b1;
        configure(1, 11'h7FF, 7);
        push_cells(MAX_COLS_DEF, 50);
        settle();

        // random maps; a phase may end mid-map so the next config applies mid-way
        rcells = 0;
        phase  = 0;
        while (rcells < RANDOM_CELLS) begin
            idle_on = (rcells < CALM_CELLS) && ($urandom_range(0, 3) != 0);
            if (phase == 0) begin
                // one-cell maps with the receiver held off: results pile up
                configure(1, 1, 46);
                hold_reqs++;
                push_cells(60, 70);
                rcells += 60;
            end else begin
                rows = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
                if ($urandom_range(0, 15) == 0) cols = 0;
                else if ($urandom_range(0, 19) == 0) cols = $urandom_range(13, 40);
                else cols = $urandom_range(1, 12);
                case ($urandom_range(0, 7)) inside
                    0: target = 0;
                    1: target = 255;
                    2, 3: target = 46;
                    default: target = $urandom_range(0, 255);
                endcase
                configure(rows, cols, target);
                area = (rows == 0 ? 1 : rows) * (cols == 0 ? 1 : cols);
                target = $urandom_range(40, 98);
                repeat ($urandom_range(1, 3)) begin
                    push_cells(area, target);
                    rcells += area;
                end
                if (area > 1 && $urandom_range(0, 3) == 0) begin
                    // leave a partial map for the next setting
                    rows = $urandom_range(1, area - 1);
                    push_cells(rows, target);
                    rcells += rows;
                end
            end
            settle();
            phase++;
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_largest_empty_square_finder: PASS");
        end else begin
            $display("tb_largest_empty_square_finder: FAIL");
        end
        $finish;
    end

endmodule

// ----- largest_empty_square_finder.f -----
rtl/lesf_pkg.sv
rtl/lesf_ram.sv
rtl/lesf_outq.sv
rtl/largest_empty_square_finder.sv
tb/tb_largest_empty_square_finder.sv
